// ----- hdl/cbt_pkg.sv -----
// ----------------------------------------------------------------------------
// cbt_pkg: shared types and constants of the cubic Bezier tessellator
// Payload structs, queue entry, lane control, state codes and the
// per-segment-count parameter step table.
// ----------------------------------------------------------------------------
package cbt_pkg;

    localparam int COORD_W      = 24;   // signed Q16.8 coordinate
    localparam int T_W          = 17;   // Q0.16 parameter, 65536 included
    localparam int T_FRAC       = 16;
    localparam int HALF_W       = 32;   // multiplier chunk width
    localparam int DIFF_W       = 64;   // difference register, two chunks
    localparam int ACC_W        = 72;   // exact numerator, modulo 2^72
    localparam int OUT_SHIFT    = 48;
    localparam int NUM_PTS      = 4;
    localparam int CNT_W        = 6;    // segment count and point counter
    localparam int SEGIDX_W     = 5;
    localparam int REM_W        = 5;

    localparam int MAX_SEGMENTS = 32;
    localparam int ARRAY_BOUND  = 32;
    localparam int SEG_LIMIT    = (MAX_SEGMENTS < ARRAY_BOUND) ? MAX_SEGMENTS : ARRAY_BOUND;

    localparam logic [CNT_W-1:0] SEG_COUNT_RESET = 6'd16;
    localparam logic [T_W-1:0]   T_ONE           = 17'h10000;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t ctrl0_x;
        coord_t ctrl0_y;
        coord_t ctrl0_z;
        coord_t ctrl1_x;
        coord_t ctrl1_y;
        coord_t ctrl1_z;
        coord_t ctrl2_x;
        coord_t ctrl2_y;
        coord_t ctrl2_z;
        coord_t ctrl3_x;
        coord_t ctrl3_y;
        coord_t ctrl3_z;
    } curve_t;

    typedef struct packed {
        coord_t                seg_start_x;
        coord_t                seg_start_y;
        coord_t                seg_start_z;
        coord_t                seg_end_x;
        coord_t                seg_end_y;
        coord_t                seg_end_z;
        logic [SEGIDX_W-1:0]   segment_index;
        logic                  last_segment;
    } segment_t;

    // Parameter step: t advances by q, plus one when the remainder wraps.
    typedef struct packed {
        logic [T_W-1:0]   q;
        logic [REM_W-1:0] r;
    } seg_step_t;

    typedef struct packed {
        curve_t           pts;
        logic [CNT_W-1:0] n;
        seg_step_t        step;
    } job_t;

    typedef enum logic [2:0] {
        LOP_IDLE,
        LOP_LOAD,
        LOP_DIFF,
        LOP_MLO,
        LOP_MHI,
        LOP_ADD,
        LOP_ROT,
        LOP_ROUND
    } lane_op_t;

    typedef struct packed {
        lane_op_t       op;
        logic [T_W-1:0] t;
    } lane_ctrl_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_LOAD,
        BK_DIFF,
        BK_MLO,
        BK_MHI,
        BK_ADD,
        BK_ROT,
        BK_ROUND,
        BK_STEP
    } back_state_t;

    // 65536 = q*n + r for each legal segment count n.
    function automatic seg_step_t seg_step(input logic [CNT_W-1:0] n);
        seg_step_t s;
        case (n)
            6'd1:    s = '{17'd65536, 5'd0};
            6'd2:    s = '{17'd32768, 5'd0};
            6'd3:    s = '{17'd21845, 5'd1};
            6'd4:    s = '{17'd16384, 5'd0};
            6'd5:    s = '{17'd13107, 5'd1};
            6'd6:    s = '{17'd10922, 5'd4};
            6'd7:    s = '{17'd9362,  5'd2};
            6'd8:    s = '{17'd8192,  5'd0};
            6'd9:    s = '{17'd7281,  5'd7};
            6'd10:   s = '{17'd6553,  5'd6};
            6'd11:   s = '{17'd5957,  5'd9};
            6'd12:   s = '{17'd5461,  5'd4};
            6'd13:   s = '{17'd5041,  5'd3};
            6'd14:   s = '{17'd4681,  5'd2};
            6'd15:   s = '{17'd4369,  5'd1};
            6'd16:   s = '{17'd4096,  5'd0};
            6'd17:   s = '{17'd3855,  5'd1};
            6'd18:   s = '{17'd3640,  5'd16};
            6'd19:   s = '{17'd3449,  5'd5};
            6'd20:   s = '{17'd3276,  5'd16};
            6'd21:   s = '{17'd3120,  5'd16};
            6'd22:   s = '{17'd2978,  5'd20};
            6'd23:   s = '{17'd2849,  5'd9};
            6'd24:   s = '{17'd2730,  5'd16};
            6'd25:   s = '{17'd2621,  5'd11};
            6'd26:   s = '{17'd2520,  5'd16};
            6'd27:   s = '{17'd2427,  5'd7};
            6'd28:   s = '{17'd2340,  5'd16};
            6'd29:   s = '{17'd2259,  5'd25};
            6'd30:   s = '{17'd2184,  5'd16};
            6'd31:   s = '{17'd2114,  5'd2};
            6'd32:   s = '{17'd2048,  5'd0};
            default: s = '{17'd65536, 5'd0};
        endcase
        return s;
    endfunction

endpackage

// ----- hdl/cbt_if.sv -----
// ----------------------------------------------------------------------------
// cbt_if: channel interfaces of the cubic Bezier tessellator
// Valid/ready channels for configuration, curve items and segment items.
// ----------------------------------------------------------------------------
interface cbt_cfg_if;
    import cbt_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] segment_count;

    modport source (output valid, output segment_count, input ready);
    modport sink   (input valid, input segment_count, output ready);
endinterface

interface cbt_curve_if;
    import cbt_pkg::*;

    logic   valid;
    logic   ready;
    curve_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cbt_segment_if;
    import cbt_pkg::*;

    logic     valid;
    logic     ready;
    segment_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/cubic_bezier_tessellator.sv -----
// ----------------------------------------------------------------------------
// cubic_bezier_tessellator: uniform tessellation of cubic Bezier curves
// Cuts each curve item into N equal-parameter segments and emits one
// segment item per segment.
// ----------------------------------------------------------------------------
// Usage:
//   cfg     - write channel for segment_count (reset 16). Zero acts as one,
//             values above 32 act as 32. Write only while the block is idle.
//   curve   - four signed Q16.8 control points per item.
//   segment - start and end point of segment i, its index and a last flag;
//             exactly N items per curve, in order.
// Evaluation:
//   Three lanes (x, y, z) compute each curve point in parallel, each with
//   one 17x32 multiplier that performs the six de Casteljau products in
//   two halves. A job queue of QUEUE_DEPTH entries sits between intake
//   and evaluator, so further curve items are taken while one is being
//   worked on.
// Reset: queue empty, no segment pending, segment_count back to 16.
// Stall: if segment is not taken, the finished item waits in the output
//   register; the evaluator holds its next point until the register frees,
//   and curve.ready drops once the queue is full.
// ----------------------------------------------------------------------------
module cubic_bezier_tessellator #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    cbt_cfg_if.sink       cfg,
    cbt_curve_if.sink     curve,
    cbt_segment_if.source segment
);
    import cbt_pkg::*;

    // intake to queue
    logic push;
    logic full;
    job_t push_job;

    // queue to evaluator
    logic pop;
    logic avail;
    job_t pop_job;

    // Intake: config register, clamp and step lookup, accept curve items.
    cbt_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .curve (curve),
        .full  (full),
        .push  (push),
        .job   (push_job)
    );

    // Decouple intake from the long per-curve evaluation.
    cbt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .pop_job  (pop_job),
        .avail    (avail)
    );

    // Evaluator: walk points k = 0..N, pair them into segment items.
    cbt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (avail),
        .job_in    (pop_job),
        .pop       (pop),
        .segment   (segment)
    );

endmodule

// ----- hdl/cbt_front.sv -----
// ----------------------------------------------------------------------------
// cbt_front: intake of the tessellator
// Holds the segment count register, clamps it and looks up the parameter
// step, and pushes each accepted curve item as a job into the queue.
// ----------------------------------------------------------------------------
module cbt_front (
    input  logic           clk,
    input  logic           rst_n,
    cbt_cfg_if.sink        cfg,
    cbt_curve_if.sink      curve,
    input  logic           full,
    output logic           push,
    output cbt_pkg::job_t  job
);
    import cbt_pkg::*;

    logic [CNT_W-1:0] seg_count_reg;
    logic [CNT_W-1:0] seg_count_next;
    logic [CNT_W-1:0] n_clamped;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        seg_count_next = seg_count_reg;
        if (cfg.valid)
        begin
            seg_count_next = cfg.segment_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_count_reg <= SEG_COUNT_RESET;
        end
        else
        begin
            seg_count_reg <= seg_count_next;
        end
    end

    // zero means one segment; saturate at the table bound
    always_comb
    begin
        if (seg_count_reg == '0)
        begin
            n_clamped = CNT_W'(1);
        end
        else if (seg_count_reg > CNT_W'(SEG_LIMIT))
        begin
            n_clamped = CNT_W'(SEG_LIMIT);
        end
        else
        begin
            n_clamped = seg_count_reg;
        end
    end

    assign curve.ready = !full;
    assign push        = curve.valid && !full;
    assign job.pts     = curve.data;
    assign job.n       = n_clamped;
    assign job.step    = seg_step(n_clamped);

endmodule

// ----- hdl/cbt_queue.sv -----
// ----------------------------------------------------------------------------
// cbt_queue: job queue between intake and evaluator
// Small circular buffer of jobs; lets the intake run ahead of the back end.
// ----------------------------------------------------------------------------
module cbt_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cbt_pkg::job_t  push_job,
    output logic           full,
    input  logic           pop,
    output cbt_pkg::job_t  pop_job,
    output logic           avail
);
    import cbt_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_QW = $clog2(DEPTH + 1);

    job_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_QW-1:0] count_reg;
    logic [CNT_QW-1:0] count_next;

    assign full    = (count_reg == CNT_QW'(DEPTH));
    assign avail   = (count_reg != '0);
    assign pop_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = CNT_QW'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNT_QW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> avail)
        else $error("job popped from an empty queue");

endmodule

// ----- hdl/cbt_lane.sv -----
// ----------------------------------------------------------------------------
// cbt_lane: one coordinate of the curve evaluator
// Exact de Casteljau evaluation on a shift line of four values, each
// product formed from two 17x32 halves, then round the Q48 numerator to Q16.8.
// ----------------------------------------------------------------------------
module cbt_lane (
    input  logic                clk,
    input  cbt_pkg::lane_ctrl_t ctrl,
    input  cbt_pkg::coord_t     pt [cbt_pkg::NUM_PTS],
    output cbt_pkg::coord_t     point
);
    import cbt_pkg::*;

    localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (OUT_SHIFT - 1);

    logic [ACC_W-1:0]          v_reg [NUM_PTS];
    logic [DIFF_W-1:0]         diff_reg;
    logic [T_W+HALF_W-1:0]     prod_lo_reg;
    logic signed [T_W+HALF_W:0] prod_hi_reg;
    logic [ACC_W-1:0]          acc_reg;
    coord_t                    point_reg;

    logic [ACC_W-1:0]          v_sub;
    logic signed [T_W:0]       t_s;
    logic signed [HALF_W-1:0]  diff_hi;
    logic signed [T_W+HALF_W:0] mul_hi;
    logic [T_W+HALF_W-1:0]     mul_lo;
    logic [ACC_W-1:0]          lo_term;
    logic [ACC_W-1:0]          hi_term;
    logic [ACC_W-1:0]          rounded;

    // each pass reads the head pair; new value enters at the tail
    assign v_sub   = v_reg[1] - v_reg[0];
    assign t_s     = signed'({1'b0, ctrl.t});
    assign diff_hi = signed'(diff_reg[DIFF_W-1:HALF_W]);
    assign mul_hi  = (T_W+HALF_W+1)'(t_s) * (T_W+HALF_W+1)'(diff_hi);
    assign mul_lo  = {{HALF_W{1'b0}}, ctrl.t} * {{T_W{1'b0}}, diff_reg[HALF_W-1:0]};
    assign lo_term = {{(ACC_W-T_W-HALF_W){1'b0}}, prod_lo_reg};
    assign hi_term = {prod_hi_reg[ACC_W-HALF_W-1:0], {HALF_W{1'b0}}};
    assign rounded = v_reg[NUM_PTS-1] + ROUND_BIAS;
    assign point   = point_reg;

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            LOP_LOAD:
            begin
                for (int i = 0; i < NUM_PTS; i++)
                begin
                    v_reg[i] <= {{(ACC_W-COORD_W){pt[i][COORD_W-1]}}, pt[i]};
                end
            end
            LOP_DIFF:
            begin
                diff_reg <= v_sub[DIFF_W-1:0];
            end
            LOP_MLO:
            begin
                prod_lo_reg <= mul_lo;
            end
            LOP_MHI:
            begin
                prod_hi_reg <= mul_hi;
                acc_reg     <= (v_reg[0] << T_FRAC) + lo_term;
            end
            LOP_ADD:
            begin
                v_reg[0] <= v_reg[1];
                v_reg[1] <= v_reg[2];
                v_reg[2] <= v_reg[3];
                v_reg[3] <= acc_reg + hi_term;
            end
            LOP_ROT:
            begin
                v_reg[0] <= v_reg[1];
                v_reg[1] <= v_reg[2];
                v_reg[2] <= v_reg[3];
                v_reg[3] <= v_reg[0];
            end
            LOP_ROUND:
            begin
                point_reg <= rounded[ACC_W-1:OUT_SHIFT];
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- hdl/cbt_back.sv -----
// ----------------------------------------------------------------------------
// cbt_back: segment sequencer and evaluator
// Walks the curve points k = 0..N, drives three coordinate lanes through
// the evaluation steps and pairs consecutive points into segment items.
// ----------------------------------------------------------------------------
module cbt_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_avail,
    input  cbt_pkg::job_t  job_in,
    output logic           pop,
    cbt_segment_if.source  segment
);
    import cbt_pkg::*;

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [1:0]         lvl_reg;
    logic [1:0]         lvl_next;
    logic [1:0]         idx_reg;
    logic [1:0]         idx_next;
    logic [CNT_W-1:0]   k_reg;
    logic [CNT_W-1:0]   k_next;
    logic [T_W-1:0]     t_reg;
    logic [T_W-1:0]     t_next;
    logic [REM_W-1:0]   rem_reg;
    logic [REM_W-1:0]   rem_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    job_t               job_reg;
    segment_t           out_data_reg;
    coord_t             prev_x_reg;
    coord_t             prev_y_reg;
    coord_t             prev_z_reg;

    logic               job_load;
    logic               prev_load;
    logic               emit;
    logic               emit_ok;
    logic [CNT_W-1:0]   step_sum;
    logic               step_wrap;
    lane_ctrl_t         lane_ctrl;
    coord_t             pt_x [NUM_PTS];
    coord_t             pt_y [NUM_PTS];
    coord_t             pt_z [NUM_PTS];
    coord_t             cur_x;
    coord_t             cur_y;
    coord_t             cur_z;

    assign pt_x[0] = job_reg.pts.ctrl0_x;
    assign pt_x[1] = job_reg.pts.ctrl1_x;
    assign pt_x[2] = job_reg.pts.ctrl2_x;
    assign pt_x[3] = job_reg.pts.ctrl3_x;
    assign pt_y[0] = job_reg.pts.ctrl0_y;
    assign pt_y[1] = job_reg.pts.ctrl1_y;
    assign pt_y[2] = job_reg.pts.ctrl2_y;
    assign pt_y[3] = job_reg.pts.ctrl3_y;
    assign pt_z[0] = job_reg.pts.ctrl0_z;
    assign pt_z[1] = job_reg.pts.ctrl1_z;
    assign pt_z[2] = job_reg.pts.ctrl2_z;
    assign pt_z[3] = job_reg.pts.ctrl3_z;

    cbt_lane u_lane_x (.clk(clk), .ctrl(lane_ctrl), .pt(pt_x), .point(cur_x));
    cbt_lane u_lane_y (.clk(clk), .ctrl(lane_ctrl), .pt(pt_y), .point(cur_y));
    cbt_lane u_lane_z (.clk(clk), .ctrl(lane_ctrl), .pt(pt_z), .point(cur_z));

    // t(k+1) = t(k) + q, plus one when the remainder reaches n
    assign step_sum  = {1'b0, rem_reg} + {1'b0, job_reg.step.r};
    assign step_wrap = (step_sum >= job_reg.n);
    assign emit_ok   = !out_valid_reg || segment.ready;

    assign segment.valid = out_valid_reg;
    assign segment.data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        t_next         = t_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && !segment.ready;
        job_load       = 1'b0;
        prev_load      = 1'b0;
        emit           = 1'b0;
        pop            = 1'b0;
        lane_ctrl.op   = LOP_IDLE;
        lane_ctrl.t    = t_reg;

        case (state_reg)
            BK_IDLE:
            begin
                if (job_avail)
                begin
                    pop        = 1'b1;
                    job_load   = 1'b1;
                    k_next     = '0;
                    t_next     = '0;
                    rem_next   = '0;
                    state_next = BK_LOAD;
                end
            end
            BK_LOAD:
            begin
                lane_ctrl.op = LOP_LOAD;
                lvl_next     = 2'd1;
                idx_next     = 2'd0;
                state_next   = BK_DIFF;
            end
            BK_DIFF:
            begin
                lane_ctrl.op = LOP_DIFF;
                state_next   = BK_MLO;
            end
            BK_MLO:
            begin
                lane_ctrl.op = LOP_MLO;
                state_next   = BK_MHI;
            end
            BK_MHI:
            begin
                lane_ctrl.op = LOP_MHI;
                state_next   = BK_ADD;
            end
            BK_ADD:
            begin
                lane_ctrl.op = LOP_ADD;
                // level L produces 4 - L values
                if (idx_reg == 2'(2'd3 - lvl_reg))
                begin
                    idx_next = 2'd0;
                    if (lvl_reg == 2'd3)
                    begin
                        state_next = BK_ROUND;
                    end
                    else
                    begin
                        state_next = BK_ROT;
                    end
                end
                else
                begin
                    idx_next   = 2'(idx_reg + 1'b1);
                    state_next = BK_DIFF;
                end
            end
            BK_ROT:
            begin
                // rotate the stale values to the tail so the new level sits at the head
                lane_ctrl.op = LOP_ROT;
                if (idx_reg == 2'(lvl_reg - 1'b1))
                begin
                    idx_next   = 2'd0;
                    lvl_next   = 2'(lvl_reg + 1'b1);
                    state_next = BK_DIFF;
                end
                else
                begin
                    idx_next = 2'(idx_reg + 1'b1);
                end
            end
            BK_ROUND:
            begin
                lane_ctrl.op = LOP_ROUND;
                state_next   = BK_STEP;
            end
            BK_STEP:
            begin
                if (k_reg == '0)
                begin
                    prev_load  = 1'b1;
                    k_next     = CNT_W'(1);
                    t_next     = T_W'(t_reg + job_reg.step.q + T_W'(step_wrap));
                    rem_next   = step_wrap ? REM_W'(step_sum - job_reg.n) : step_sum[REM_W-1:0];
                    state_next = BK_LOAD;
                end
                else if (emit_ok)
                begin
                    emit           = 1'b1;
                    prev_load      = 1'b1;
                    out_valid_next = 1'b1;
                    if (k_reg == job_reg.n)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        k_next     = CNT_W'(k_reg + 1'b1);
                        t_next     = T_W'(t_reg + job_reg.step.q + T_W'(step_wrap));
                        rem_next   = step_wrap ? REM_W'(step_sum - job_reg.n)
                                               : step_sum[REM_W-1:0];
                        state_next = BK_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            lvl_reg       <= '0;
            idx_reg       <= '0;
            k_reg         <= '0;
            t_reg         <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            idx_reg       <= idx_next;
            k_reg         <= k_next;
            t_reg         <= t_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            job_reg <= job_in;
        end
        if (prev_load)
        begin
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
            prev_z_reg <= cur_z;
        end
        if (emit)
        begin
            out_data_reg.seg_start_x   <= prev_x_reg;
            out_data_reg.seg_start_y   <= prev_y_reg;
            out_data_reg.seg_start_z   <= prev_z_reg;
            out_data_reg.seg_end_x     <= cur_x;
            out_data_reg.seg_end_y     <= cur_y;
            out_data_reg.seg_end_z     <= cur_z;
            out_data_reg.segment_index <= SEGIDX_W'(k_reg - 1'b1);
            out_data_reg.last_segment  <= (k_reg == job_reg.n);
        end
    end

    a_t_ends_at_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_STEP && k_reg == job_reg.n) |-> (t_reg == T_ONE))
        else $error("parameter does not reach one at the last point");

    a_rem_below_n: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BK_IDLE) |-> (rem_reg < job_reg.n))
        else $error("parameter remainder out of range");

    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BK_IDLE) |-> (k_reg <= job_reg.n && job_reg.n != '0))
        else $error("point counter beyond segment count");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !segment.ready) |-> !emit)
        else $error("pending segment item overwritten");

endmodule

// ----- verif/tb_cubic_bezier_tessellator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cubic_bezier_tessellator: self-checking bench of the Bezier tessellator
// Feeds curve items over valid/ready with random gaps and back-pressure. It
// rewrites segment_count between phases, including zero and values above the
// cap. Each segment item is compared field by field against an exact
// fixed-point tessellation computed inside the bench.
// ----------------------------------------------------------------------------
module tb_cubic_bezier_tessellator;
    import cbt_pkg::*;

    localparam int     RANDOM_ITEMS   = 110;
    localparam int     SETTLE_CYCLES  = 80;    // evaluator tail after the last item
    localparam int     TAIL_CYCLES    = 200;   // catch stray items after the drain
    localparam int     HOLD_CYCLES    = 600;   // long receiver hold-off
    localparam int     WATCHDOG_LIMIT = 5000;  // quiet cycles before giving up
    localparam int     MAX_REPORTS    = 40;
    localparam coord_t COORD_MAX      = 24'sh7FFFFF;
    localparam coord_t COORD_MIN      = 24'sh800000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Bench-side copies of every block input, known from time zero.
    logic             cfg_valid   = 1'b0;
    logic [CNT_W-1:0] cfg_value   = '0;
    logic             curve_valid = 1'b0;
    curve_t           curve_data  = '0;
    logic             seg_ready   = 1'b0;

    cbt_cfg_if     cfg_bus ();
    cbt_curve_if   curve_bus ();
    cbt_segment_if segment_bus ();

    assign cfg_bus.valid         = cfg_valid;
    assign cfg_bus.segment_count = cfg_value;
    assign curve_bus.valid       = curve_valid;
    assign curve_bus.data        = curve_data;
    assign segment_bus.ready     = seg_ready;

    cubic_bezier_tessellator uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .curve   (curve_bus),
        .segment (segment_bus)
    );

    curve_t           pending_curves[$];   // items waiting to be offered
    segment_t         segments_due[$];     // predicted segment items, oldest first
    logic [CNT_W-1:0] segment_setting = SEG_COUNT_RESET;  // mirror of the register
    int               mismatch_count  = 0;
    int unsigned      segments_seen   = 0;
    int unsigned      curves_queued   = 0;
    int unsigned      idle_left       = 0;
    int unsigned      stall_left      = 0;
    int unsigned      quiet_cycles    = 0;
    int               hold_asks       = 0;
    int               hold_served     = 0;
    bit               sender_calm     = 1'b0;
    bit               receiver_calm   = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor: exact fixed-point evaluation of the curve.
    // ------------------------------------------------------------------------

    // One coordinate at Q0.16 parameter t. The numerator is exact; add half an
    // output LSB and shift arithmetically, which rounds to nearest, ties toward plus infinity.
    function automatic coord_t bezier_coord(input coord_t c0, c1, c2, c3,
                                            input int unsigned t);
        logic signed [95:0] tt;
        logic signed [95:0] uu;
        logic signed [95:0] num;
        logic signed [95:0] scaled;
        tt     = 96'(t);
        uu     = 96'(65536 - t);
        num    = uu * uu * uu * 96'(c0) + 96'sd3 * uu * uu * tt * 96'(c1)
               + 96'sd3 * uu * tt * tt * 96'(c2) + tt * tt * tt * 96'(c3)
               + (96'sd1 <<< 47);
        scaled = num >>> OUT_SHIFT;
        return scaled[COORD_W-1:0];
    endfunction

    function automatic void curve_point(input curve_t c, input int unsigned t,
                                        output coord_t x, y, z);
        x = bezier_coord(c.ctrl0_x, c.ctrl1_x, c.ctrl2_x, c.ctrl3_x, t);
        y = bezier_coord(c.ctrl0_y, c.ctrl1_y, c.ctrl2_y, c.ctrl3_y, t);
        z = bezier_coord(c.ctrl0_z, c.ctrl1_z, c.ctrl2_z, c.ctrl3_z, t);
    endfunction

    // Queue the N segment items one accepted curve must produce.
    function automatic void tessellate_curve(input curve_t c);
        int unsigned n;
        int unsigned k;
        segment_t    s;
        // Zero acts as one; anything above the cap saturates to it.
        if (segment_setting == 0)
            n = 1;
        else if (segment_setting > SEG_LIMIT)
            n = SEG_LIMIT;
        else
            n = 32'(segment_setting);
        for (k = 0; k < n; k++)
        begin
            curve_point(c, (k * 65536) / n, s.seg_start_x, s.seg_start_y, s.seg_start_z);
            curve_point(c, ((k + 1) * 65536) / n, s.seg_end_x, s.seg_end_y, s.seg_end_z);
            s.segment_index = SEGIDX_W'(k);
            s.last_segment  = (k == n - 1);
            segments_due.push_back(s);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t segment item %0d, %s: got %0d, expected %0d",
                     $time, segments_seen, what, got, want);
    endtask

    task automatic check_segment(input segment_t got);
        segment_t want;
        if (segments_due.size() == 0)
        begin
            flag_mismatch("item with nothing due, segment_index", got.segment_index, -1);
        end
        else
        begin
            want = segments_due.pop_front();
            if (got.seg_start_x !== want.seg_start_x)
                flag_mismatch("seg_start_x", got.seg_start_x, want.seg_start_x);
            if (got.seg_start_y !== want.seg_start_y)
                flag_mismatch("seg_start_y", got.seg_start_y, want.seg_start_y);
            if (got.seg_start_z !== want.seg_start_z)
                flag_mismatch("seg_start_z", got.seg_start_z, want.seg_start_z);
            if (got.seg_end_x !== want.seg_end_x)
                flag_mismatch("seg_end_x", got.seg_end_x, want.seg_end_x);
            if (got.seg_end_y !== want.seg_end_y)
                flag_mismatch("seg_end_y", got.seg_end_y, want.seg_end_y);
            if (got.seg_end_z !== want.seg_end_z)
                flag_mismatch("seg_end_z", got.seg_end_z, want.seg_end_z);
            if (got.segment_index !== want.segment_index)
                flag_mismatch("segment_index", got.segment_index, want.segment_index);
            if (got.last_segment !== want.last_segment)
                flag_mismatch("last_segment", got.last_segment, want.last_segment);
        end
        segments_seen++;
    endtask

    // Monitor: track register writes, predict on each accepted curve and
    // compare each accepted segment item. Push before pop within one edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_bus.ready)
                segment_setting = cfg_value;
            if (curve_valid && curve_bus.ready)
                tessellate_curve(curve_data);
            if (segment_bus.valid && seg_ready)
                check_segment(segment_bus.data);
        end
    end

    // ------------------------------------------------------------------------
    // Driver and receiver
    // ------------------------------------------------------------------------

    // Mostly short gaps, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Curve driver: hold an offered item until taken, then idle for a random
    // gap (none when calm) before offering the next pending one.
    always @(posedge clk)
    begin : drive_curves
        int unsigned gap;
        if (!rst_n)
        begin
            curve_valid <= 1'b0;
            idle_left   <= 0;
        end
        else if (!(curve_valid && !curve_bus.ready))
        begin
            gap = (curve_valid && !sender_calm) ? pick_gap() : 0;
            if (idle_left != 0)
            begin
                idle_left   <= idle_left - 1;
                curve_valid <= 1'b0;
            end
            else if (gap != 0)
            begin
                idle_left   <= gap - 1;
                curve_valid <= 1'b0;
            end
            else if (pending_curves.size() != 0)
            begin
                curve_data  <= pending_curves.pop_front();
                curve_valid <= 1'b1;
            end
            else
            begin
                curve_valid <= 1'b0;
            end
        end
    end

    // Segment receiver: a requested hold-off wins; otherwise stall at random
    // unless calm.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            seg_ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (hold_served != hold_asks)
        begin
            hold_served <= hold_asks;
            stall_left  <= HOLD_CYCLES;
            seg_ready   <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            seg_ready  <= 1'b0;
        end
        else if (receiver_calm || $urandom_range(0, 99) >= 25)
        begin
            seg_ready <= 1'b1;
        end
        else
        begin
            stall_left <= pick_gap();
            seg_ready  <= 1'b0;
        end
    end

    // Watchdog: give up after a long stretch with no handshake on any channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cfg_valid && cfg_bus.ready) || (curve_valid && curve_bus.ready)
                || (segment_bus.valid && seg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t no progress for %0d cycles, %0d segment items still due",
                         $time, quiet_cycles, segments_due.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Spread four values over the three axes in different orders.
    function automatic curve_t curve_of(input coord_t a, b, c, d);
        curve_t k;
        k.ctrl0_x = a;  k.ctrl1_x = b;  k.ctrl2_x = c;  k.ctrl3_x = d;
        k.ctrl0_y = d;  k.ctrl1_y = c;  k.ctrl2_y = b;  k.ctrl3_y = a;
        k.ctrl0_z = b;  k.ctrl1_z = a;  k.ctrl2_z = d;  k.ctrl3_z = c;
        return k;
    endfunction

    // Mostly full-range values, some near zero, some at the rails.
    function automatic coord_t random_coord();
        logic [31:0] r;
        int unsigned roll;
        r    = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return r[COORD_W-1:0];
        if (roll < 85)
            return coord_t'($urandom_range(0, 1023)) - 24'sd512;
        case (r[2:0])
            3'd0:    return COORD_MAX;
            3'd1:    return COORD_MIN;
            3'd2:    return COORD_MAX - 1;
            3'd3:    return COORD_MIN + 1;
            3'd4:    return -24'sd1;
            default: return '0;
        endcase
    endfunction

    task automatic queue_curve(input curve_t c);
        pending_curves.push_back(c);
        curves_queued++;
    endtask

    // Enqueue at the falling edge so the driver never races the push.
    task automatic queue_random_curves(input int count);
        curve_t c;
        @(negedge clk);
        sender_calm   = ($urandom_range(0, 3) == 0);
        receiver_calm = ($urandom_range(0, 3) == 0);
        repeat (count)
        begin
            c.ctrl0_x = random_coord();  c.ctrl0_y = random_coord();
            c.ctrl0_z = random_coord();  c.ctrl1_x = random_coord();
            c.ctrl1_y = random_coord();  c.ctrl1_z = random_coord();
            c.ctrl2_x = random_coord();  c.ctrl2_y = random_coord();
            c.ctrl2_z = random_coord();  c.ctrl3_x = random_coord();
            c.ctrl3_y = random_coord();  c.ctrl3_z = random_coord();
            queue_curve(c);
        end
    endtask

    // Block until nothing is pending, offered or due.
    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (pending_curves.size() != 0 || curve_valid || segments_due.size() != 0);
    endtask

    // Rewrite segment_count only once the block has gone idle.
    task automatic apply_segment_count(input logic [CNT_W-1:0] value);
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_value <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [CNT_W-1:0] setting;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed curves at the reset setting of 16 segments: rails, zero,
        // single weights isolated, rounding of small negatives, bit patterns.
        @(negedge clk);
        queue_curve(curve_of('0, '0, '0, '0));
        queue_curve(curve_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        queue_curve(curve_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        queue_curve(curve_of(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
        queue_curve(curve_of(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
        queue_curve(curve_of(COORD_MAX, '0, '0, '0));
        queue_curve(curve_of('0, COORD_MAX, '0, '0));
        queue_curve(curve_of('0, '0, COORD_MIN, '0));
        queue_curve(curve_of('0, '0, '0, COORD_MAX));
        queue_curve(curve_of(-24'sd1, -24'sd1, -24'sd1, -24'sd1));
        queue_curve(curve_of(24'sd1, -24'sd1, 24'sd1, -24'sd1));
        queue_curve(curve_of('0, COORD_MAX, COORD_MAX, '0));
        queue_curve(curve_of(24'sd0, 24'sd1000, 24'sd2000, 24'sd3000));
        queue_curve(curve_of(24'shAAAAAA, 24'sh555555, 24'sh555555, 24'shAAAAAA));

        // Zero segments behaves as one.
        apply_segment_count(6'd0);
        queue_random_curves(12);

        // Largest code saturates to the cap; keep these few, they are slow.
        apply_segment_count(6'd63);
        queue_random_curves(2);

        // Back-pressure: offer items with no gaps while the receiver holds off
        // for a long stretch, so the queue fills and curve.ready drops.
        apply_segment_count(6'd2);
        queue_random_curves(12);
        sender_calm = 1'b1;
        hold_asks++;

        apply_segment_count(6'd33);
        queue_random_curves(1);

        apply_segment_count(6'd1);
        queue_random_curves(10);

        apply_segment_count(6'd32);
        queue_random_curves(2);

        apply_segment_count(6'd31);
        queue_random_curves(1);

        // Random settings, mostly small so the run stays short.
        while (curves_queued < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 99) < 80)
                setting = CNT_W'($urandom_range(0, 8));
            else
                setting = CNT_W'($urandom_range(9, 63));
            apply_segment_count(setting);
            if (setting > 16)
                queue_random_curves($urandom_range(1, 2));
            else
                queue_random_curves($urandom_range(4, 12));
        end

        // Anything still due after this is caught by the watchdog.
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/cbt_pkg.sv
hdl/cbt_if.sv
hdl/cbt_front.sv
hdl/cbt_queue.sv
hdl/cbt_lane.sv
hdl/cbt_back.sv
hdl/cubic_bezier_tessellator.sv
verif/tb_cubic_bezier_tessellator.sv
